// ===== hw/rtl/triangle_ground_height_query_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ground height query block
// Shared concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_GROUND_HEIGHT_QUERY_TOP_MACROS_SVH
`define TRIANGLE_GROUND_HEIGHT_QUERY_TOP_MACROS_SVH

// same-cycle implication
`define TGHQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tghq: same-cycle check failed");

// next-cycle implication
`define TGHQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tghq: next-cycle check failed");

`endif

// ===== hw/rtl/tghq_pkg.sv =====
// ----------------------------------------------------------------------------
// tghq_pkg
// Shared types and constants of the ground height query block.
// ----------------------------------------------------------------------------
package tghq_pkg;

    // operation of the shared serial unit
    typedef enum logic {
        OP_MUL,
        OP_DIV
    } tghq_op_t;

    localparam int CNT_W = 8;

    // command to the serial unit
    typedef struct packed {
        tghq_op_t         op;
        logic             load;
        logic             sub;
        logic [CNT_W-1:0] count;
    } tghq_cmd_t;

    // register map (word index)
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_FLOOR   = 2'd0;
    localparam logic [1:0] REG_CEILING = 2'd1;
    localparam logic [1:0] REG_COSINE  = 2'd2;

    // n.y^2 scale that matches a squared Q1.15 cosine
    localparam int COS_SQ_FRAC = 30;

endpackage

// ===== hw/rtl/tghq_in_if.sv =====
// ----------------------------------------------------------------------------
// tghq_in_if
// Triangle input channel: valid/ready plus one triangle and the probe point.
// ----------------------------------------------------------------------------
interface tghq_in_if #(
    parameter int COORD_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;
    logic signed [COORD_BITS-1:0] probe_x;
    logic signed [COORD_BITS-1:0] probe_z;
    logic                         final_triangle;

    modport source (
        output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
               probe_x, probe_z, final_triangle,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
               probe_x, probe_z, final_triangle,
        output ready
    );
endinterface

// ===== hw/rtl/tghq_out_if.sv =====
// ----------------------------------------------------------------------------
// tghq_out_if
// Result channel: valid/ready plus found flag and ground height.
// ----------------------------------------------------------------------------
interface tghq_out_if #(
    parameter int COORD_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic signed [COORD_BITS-1:0] height;

    modport source (
        output valid, found, height,
        input  ready
    );
    modport sink (
        input  valid, found, height,
        output ready
    );
endinterface

// ===== hw/rtl/triangle_ground_height_query_top.sv =====
// ----------------------------------------------------------------------------
// triangle_ground_height_query_top
// Highest accepted ground height under a probe point over a triangle stream.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | word
//  ---------+-----+-----------------+---------------------------------------
//  tri_in   | in  | valid/ready     | vertices a,b,c, probe x/z, final flag
//  res_out  | out | valid/ready     | found, height (final triangle only)
//  apb      | in  | psel/penable    | floor, ceiling, min up cosine
//
//  A triangle that passes every test runs 20 serial operations on the
//  bit-serial shift-add/divide unit, each issued in ST_ISSUE and awaited
//  in ST_WAIT until done. A triangle whose normal does not point up is
//  done once the normal's y component is known; the other skip tests end
//  it at their own step.
//  tri_in.ready is high only while idle; a finished result waits in the output
//  register and the next triangle may be taken meanwhile. A final triangle
//  holds until the previous result word has been taken.
//  Reset is asynchronous; it clears the query and restores register defaults.
// ----------------------------------------------------------------------------
module triangle_ground_height_query_top #(
    parameter int COORD_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tghq_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    tghq_in_if.sink                          tri_in,
    tghq_out_if.source                       res_out
);

    localparam int E    = COORD_BITS + 1;
    localparam int P    = 2 * COORD_BITS + 3;
    localparam int W    = 4 * COORD_BITS + 48;
    localparam int MB   = P;
    localparam int QB   = COORD_BITS + 2;
    localparam int HW   = COORD_BITS + 3;
    localparam int LW   = 2 * P;
    localparam int SW   = 2 * P + 2;
    localparam int NW   = P + E + 1;
    localparam int C2W  = 34;
    localparam int CMPW = (HW > 32) ? HW + 1 : 33;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_SUMCHK,
        ST_HEIGHT,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef enum logic [4:0] {
        S_NX_A, S_NX_B, S_NY_A, S_NY_B, S_NZ_A, S_NZ_B,
        S_D_A, S_D_B, S_U_A, S_U_B, S_V_A, S_V_B,
        S_NY2, S_NX2, S_NZ2, S_CM2, S_RHS, S_NUM_A, S_NUM_B, S_DIV
    } step_t;

    // configuration
    logic signed [31:0] floor_reg;
    logic signed [31:0] ceiling_reg;
    logic [15:0]        cosine_reg;

    // sequencer state
    state_t               state_reg;
    step_t                step_reg;
    logic signed [E-1:0]  e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [E-1:0]  qx_reg, qz_reg;
    logic signed [COORD_BITS-1:0] ay_reg;
    logic                 last_reg;
    logic signed [P-1:0]  nx_reg, ny_reg, nz_reg, d_reg, u_reg, v_reg;
    logic                 dneg_reg;
    logic signed [LW-1:0] lsq_reg;
    logic signed [SW-1:0] ssq_reg;
    logic signed [C2W-1:0] c2_reg;
    logic signed [NW-1:0] num_reg;
    logic signed [HW-1:0] h_reg;
    logic signed [HW-1:0] best_reg;
    logic                 found_reg;
    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic signed [COORD_BITS-1:0] out_height_reg;

    // serial unit hookup
    logic                 u_start;
    tghq_pkg::tghq_cmd_t  u_cmd;
    logic signed [W-1:0]  u_init, u_mcand, u_acc;
    logic [MB-1:0]        u_mplier, u_quo;
    logic                 u_done;

    logic signed [W-1:0]  acc_neg, acc_fix, num_w, lhs_w;
    logic signed [HW-1:0] q_ext, q_adj;
    logic                 rem_nz;
    logic                 cfg_wr;
    logic                 in_acc;
    logic                 in_range;
    logic                 out_load;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= 32'sh8000_0000;
            ceiling_reg <= 32'sh7FFF_FFFF;
            cosine_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                tghq_pkg::REG_FLOOR:   floor_reg   <= pwdata;
                tghq_pkg::REG_CEILING: ceiling_reg <= pwdata;
                tghq_pkg::REG_COSINE:  cosine_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb
    begin
        unique case (paddr[3:2])
            tghq_pkg::REG_FLOOR:   prdata = floor_reg;
            tghq_pkg::REG_CEILING: prdata = ceiling_reg;
            tghq_pkg::REG_COSINE:  prdata = {16'd0, cosine_reg};
            default:               prdata = '0;
        endcase
    end

    // operand selection for the current serial step
    always_comb
    begin
        u_cmd.op    = tghq_pkg::OP_MUL;
        u_cmd.load  = 1'b1;
        u_cmd.sub   = 1'b0;
        u_cmd.count = tghq_pkg::CNT_W'(E);
        u_init      = '0;
        u_mcand     = '0;
        u_mplier    = '0;
        num_w       = W'(num_reg);
        unique case (step_reg)
            S_NX_A: begin u_mcand = W'(e1y_reg); u_mplier = MB'(e2z_reg); end
            S_NX_B:
            begin
                u_mcand = W'(e1z_reg); u_mplier = MB'(e2y_reg);
                u_cmd.load = 1'b0; u_cmd.sub = 1'b1;
            end
            S_NY_A: begin u_mcand = W'(e1z_reg); u_mplier = MB'(e2x_reg); end
            S_NY_B:
            begin
                u_mcand = W'(e1x_reg); u_mplier = MB'(e2z_reg);
                u_cmd.load = 1'b0; u_cmd.sub = 1'b1;
            end
            S_NZ_A: begin u_mcand = W'(e1x_reg); u_mplier = MB'(e2y_reg); end
            S_NZ_B:
            begin
                u_mcand = W'(e1y_reg); u_mplier = MB'(e2x_reg);
                u_cmd.load = 1'b0; u_cmd.sub = 1'b1;
            end
            S_D_A:  begin u_mcand = W'(e1x_reg); u_mplier = MB'(e2z_reg); end
            S_D_B:
            begin
                u_mcand = W'(e2x_reg); u_mplier = MB'(e1z_reg);
                u_cmd.load = 1'b0; u_cmd.sub = 1'b1;
            end
            S_U_A:  begin u_mcand = W'(qx_reg); u_mplier = MB'(e2z_reg); end
            S_U_B:
            begin
                u_mcand = W'(e2x_reg); u_mplier = MB'(qz_reg);
                u_cmd.load = 1'b0; u_cmd.sub = 1'b1;
            end
            S_V_A:  begin u_mcand = W'(e1x_reg); u_mplier = MB'(qz_reg); end
            S_V_B:
            begin
                u_mcand = W'(qx_reg); u_mplier = MB'(e1z_reg);
                u_cmd.load = 1'b0; u_cmd.sub = 1'b1;
            end
            S_NY2:
            begin
                u_mcand = W'(ny_reg); u_mplier = MB'(ny_reg);
                u_cmd.count = tghq_pkg::CNT_W'(P);
            end
            S_NX2:
            begin
                u_mcand = W'(nx_reg); u_mplier = MB'(nx_reg);
                u_cmd.count = tghq_pkg::CNT_W'(P); u_cmd.load = 1'b0;
            end
            S_NZ2:
            begin
                u_mcand = W'(nz_reg); u_mplier = MB'(nz_reg);
                u_cmd.count = tghq_pkg::CNT_W'(P); u_cmd.load = 1'b0;
            end
            S_CM2:
            begin
                u_mcand = W'({1'b0, cosine_reg}); u_mplier = MB'({1'b0, cosine_reg});
                u_cmd.count = tghq_pkg::CNT_W'(17);
            end
            S_RHS:
            begin
                u_mcand = W'(ssq_reg); u_mplier = MB'(c2_reg);
                u_cmd.count = tghq_pkg::CNT_W'(C2W);
            end
            S_NUM_A: begin u_mcand = W'(u_reg); u_mplier = MB'(e1y_reg); end
            S_NUM_B:
            begin
                u_mcand = W'(v_reg); u_mplier = MB'(e2y_reg); u_cmd.load = 1'b0;
            end
            S_DIV:
            begin
                u_cmd.op    = tghq_pkg::OP_DIV;
                u_cmd.count = tghq_pkg::CNT_W'(QB);
                u_init      = num_reg[NW-1] ? -num_w : num_w;
                u_mcand     = W'(d_reg) <<< (QB - 1);
            end
            default: ;
        endcase
    end

    // result fixups
    always_comb
    begin
        acc_neg  = -u_acc;
        acc_fix  = dneg_reg ? acc_neg : u_acc;
        lhs_w    = W'(lsq_reg) <<< tghq_pkg::COS_SQ_FRAC;
        rem_nz   = |u_acc;
        q_ext    = HW'({1'b0, u_quo[QB-1:0]});
        q_adj    = num_reg[NW-1] ? -(q_ext + HW'(rem_nz)) : q_ext;
        in_range = (CMPW'(h_reg) >= CMPW'(floor_reg))
                && (CMPW'(h_reg) <= CMPW'(ceiling_reg));
    end

    assign u_start  = (state_reg == ST_ISSUE);
    assign in_acc   = tri_in.valid && tri_in.ready;
    assign out_load = (state_reg == ST_FINISH) && last_reg
                   && (!out_valid_reg || res_out.ready);

    tghq_serial_unit #(
        .W  (W),
        .MB (MB)
    ) u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (u_start),
        .cmd    (u_cmd),
        .init   (u_init),
        .mcand  (u_mcand),
        .mplier (u_mplier),
        .done   (u_done),
        .acc    (u_acc),
        .quo    (u_quo)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= S_NX_A;
            e1x_reg <= '0; e1y_reg <= '0; e1z_reg <= '0;
            e2x_reg <= '0; e2y_reg <= '0; e2z_reg <= '0;
            qx_reg  <= '0; qz_reg  <= '0; ay_reg  <= '0;
            last_reg       <= 1'b0;
            nx_reg <= '0; ny_reg <= '0; nz_reg <= '0;
            d_reg  <= '0; u_reg  <= '0; v_reg  <= '0;
            dneg_reg       <= 1'b0;
            lsq_reg        <= '0;
            ssq_reg        <= '0;
            c2_reg         <= '0;
            num_reg        <= '0;
            h_reg          <= '0;
            best_reg       <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_height_reg <= '0;
        end
        else
        begin
            // result word register: load wins over drain
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        e1x_reg  <= E'(tri_in.b_x) - E'(tri_in.a_x);
                        e1y_reg  <= E'(tri_in.b_y) - E'(tri_in.a_y);
                        e1z_reg  <= E'(tri_in.b_z) - E'(tri_in.a_z);
                        e2x_reg  <= E'(tri_in.c_x) - E'(tri_in.a_x);
                        e2y_reg  <= E'(tri_in.c_y) - E'(tri_in.a_y);
                        e2z_reg  <= E'(tri_in.c_z) - E'(tri_in.a_z);
                        qx_reg   <= E'(tri_in.probe_x) - E'(tri_in.a_x);
                        qz_reg   <= E'(tri_in.probe_z) - E'(tri_in.a_z);
                        ay_reg   <= tri_in.a_y;
                        last_reg <= tri_in.final_triangle;
                        step_reg <= S_NX_A;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (u_done)
                    begin
                        step_reg <= step_t'(step_reg + 5'd1);
                        case (step_reg)
                            S_NX_B:
                            begin
                                nx_reg    <= P'(u_acc);
                                state_reg <= ST_ISSUE;
                            end
                            S_NY_B:
                            begin
                                ny_reg <= P'(u_acc);
                                // normal not pointing up
                                state_reg <= (u_acc[W-1] || (u_acc == '0)) ? ST_FINISH
                                                                           : ST_ISSUE;
                            end
                            S_NZ_B:
                            begin
                                nz_reg    <= P'(u_acc);
                                state_reg <= ST_ISSUE;
                            end
                            S_D_B:
                            begin
                                dneg_reg <= u_acc[W-1];
                                d_reg    <= P'(u_acc[W-1] ? acc_neg : u_acc);
                                // degenerate xz projection
                                state_reg <= (u_acc == '0) ? ST_FINISH : ST_ISSUE;
                            end
                            S_U_B:
                            begin
                                u_reg     <= P'(acc_fix);
                                state_reg <= acc_fix[W-1] ? ST_FINISH : ST_ISSUE;
                            end
                            S_V_B:
                            begin
                                v_reg <= P'(acc_fix);
                                state_reg <= acc_fix[W-1] ? ST_FINISH : ST_SUMCHK;
                            end
                            S_NY2:
                            begin
                                lsq_reg   <= LW'(u_acc);
                                state_reg <= ST_ISSUE;
                            end
                            S_NZ2:
                            begin
                                ssq_reg   <= SW'(u_acc);
                                state_reg <= ST_ISSUE;
                            end
                            S_CM2:
                            begin
                                c2_reg    <= C2W'(u_acc);
                                state_reg <= ST_ISSUE;
                            end
                            S_RHS:
                            begin
                                // too steep for min up cosine
                                state_reg <= (lhs_w < u_acc) ? ST_FINISH : ST_ISSUE;
                            end
                            S_NUM_B:
                            begin
                                num_reg   <= NW'(u_acc);
                                state_reg <= ST_ISSUE;
                            end
                            S_DIV:   state_reg <= ST_HEIGHT;
                            default: state_reg <= ST_ISSUE;
                        endcase
                    end
                end
                ST_SUMCHK:
                begin
                    // u + v <= d, inclusive
                    if ((P+1)'(u_reg) + (P+1)'(v_reg) > (P+1)'(d_reg))
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        step_reg  <= S_NY2;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_HEIGHT:
                begin
                    h_reg     <= HW'(ay_reg) + q_adj;
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    // equal height keeps the earlier one
                    if (in_range && (!found_reg || (h_reg > best_reg)))
                    begin
                        best_reg  <= h_reg;
                        found_reg <= 1'b1;
                    end
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_load)
                    begin
                        out_found_reg  <= found_reg;
                        out_height_reg <= found_reg ? COORD_BITS'(best_reg) : '0;
                        found_reg      <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign tri_in.ready   = (state_reg == ST_IDLE);
    assign res_out.valid  = out_valid_reg;
    assign res_out.found  = out_found_reg;
    assign res_out.height = out_height_reg;

endmodule

// ===== hw/rtl/tghq_serial_unit.sv =====
// ----------------------------------------------------------------------------
// tghq_serial_unit
// Shared shift-add multiplier / restoring divider around one wide adder.
// ----------------------------------------------------------------------------
module tghq_serial_unit #(
    parameter int W  = 176,
    parameter int MB = 67
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tghq_pkg::tghq_cmd_t cmd,
    input  logic signed [W-1:0] init,
    input  logic signed [W-1:0] mcand,
    input  logic [MB-1:0]       mplier,
    output logic                done,
    output logic signed [W-1:0] acc,
    output logic [MB-1:0]       quo
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [tghq_pkg::CNT_W-1:0]   left_reg;
    tghq_pkg::tghq_op_t           op_reg;
    logic                         sub_reg;
    logic signed [W-1:0]          acc_reg;
    logic signed [W-1:0]          mc_reg;
    logic [MB-1:0]                mp_reg;

    logic                         last;
    logic                         neg;
    logic [W-1:0]                 operand;
    logic signed [W-1:0]          sum;
    logic                         take;

    // one adder: multiply adds/subtracts shifted multiplicand, divide trial-subtracts
    always_comb
    begin
        last    = (left_reg == tghq_pkg::CNT_W'(1));
        neg     = (op_reg == tghq_pkg::OP_DIV) || (sub_reg ^ last);
        operand = mc_reg ^ {W{neg}};
        sum     = acc_reg + $signed(operand) + $signed(W'(neg));
        take    = (op_reg == tghq_pkg::OP_DIV) ? !sum[W-1] : mp_reg[0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
            op_reg   <= tghq_pkg::OP_MUL;
            sub_reg  <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            left_reg <= cmd.count;
            op_reg   <= cmd.op;
            sub_reg  <= cmd.sub;
        end
        else if (busy_reg)
        begin
            left_reg <= left_reg - tghq_pkg::CNT_W'(1);
            busy_reg <= !last;
            done_reg <= last;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (cmd.load)
            begin
                acc_reg <= init;
            end
            mc_reg <= mcand;
            mp_reg <= mplier;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                acc_reg <= sum;
            end
            if (op_reg == tghq_pkg::OP_DIV)
            begin
                mc_reg <= mc_reg >>> 1;
                mp_reg <= {mp_reg[MB-2:0], take};
            end
            else
            begin
                mc_reg <= mc_reg <<< 1;
                mp_reg <= mp_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign quo  = mp_reg;

endmodule

// ===== hw/rtl/tghq_checker.sv =====
// ----------------------------------------------------------------------------
// tghq_checker
// Port-level checks of the ground height query block, bound to the top.
// ----------------------------------------------------------------------------
`include "triangle_ground_height_query_top_macros.svh"

module tghq_checker #(
    parameter int COORD_BITS = 32
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  out_found,
    input logic [COORD_BITS-1:0] out_height
);

    // stalled result word holds
    `TGHQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_height) && $stable(out_found))

    // nothing found reports zero height
    `TGHQ_ASSERT_SAME(a_zero_height, clk, rst_n, out_valid && !out_found, out_height == '0)

    // the block is not ready in the cycle after it takes a triangle
    `TGHQ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind triangle_ground_height_query_top tghq_checker #(
    .COORD_BITS (COORD_BITS)
) u_tghq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (tri_in.valid),
    .in_ready   (tri_in.ready),
    .out_valid  (res_out.valid),
    .out_ready  (res_out.ready),
    .out_found  (res_out.found),
    .out_height (res_out.height)
);
